// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MSFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

`define MSFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`else

`define MSFA_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define MSFA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/msfa_pkg.sv -----
// shared types, codes and constants of the feature admit unit
`default_nettype none

package msfa_pkg;

   localparam int DEF_CAPACITY   = 128;
   localparam int DEF_COORD_BITS = 12;

   localparam int OP_W       = 2;
   localparam int POS_W      = 12;
   localparam int RESP_W     = 16;
   localparam int ID_W       = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 8;
   localparam int SEP_W      = 26;
   localparam int MAXF_W     = 8;
   localparam int LIMIT_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 26;

   localparam logic [RESP_W-1:0]  RST_MIN_RESP  = RESP_W'(70);
   localparam logic [SEP_W-1:0]   RST_MIN_SEP   = SEP_W'(225);
   localparam logic [MAXF_W-1:0]  RST_MAX_FEAT  = MAXF_W'(100);
   localparam logic [LIMIT_W-1:0] RST_CAND_LIM  = LIMIT_W'(1500);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR     = 2'd0,
      OP_LOAD      = 2'd1,
      OP_CANDIDATE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_CLOSE    = 3'd1,
      ST_LOWRESP  = 3'd2,
      ST_LIMIT    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RESP  = 2'd0,
      CSR_MIN_SEP   = 2'd1,
      CSR_MAX_FEAT  = 2'd2,
      CSR_CAND_LIM  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SEARCH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic start_search;
      logic search_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_search;
      logic issue_done;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/msfa_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module msfa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/msfa_ctrl.sv -----
// controller state machine: item intake, store scan sequencing, result hand-off
`default_nettype none
`include "assert_macros.svh"

module msfa_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire msfa_pkg::dp_status_type dp_status,
   output msfa_pkg::ctrl_cmd_type       cmd
);

   import msfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (dp_status.needs_search) begin
               cmd.start_search = 1'b1;
               state_in         = S_SEARCH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SEARCH: begin
            if (!dp_status.issue_done) begin
               cmd.search_step = 1'b1;
            end else if (!dp_status.pipe_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (dp_status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `MSFA_ASSERT_IMPLY(a_step_only_pending, clock, reset, cmd.search_step, !dp_status.issue_done)
   `MSFA_ASSERT_IMPLY(a_finish_drained, clock, reset, state_ff == S_FINISH, !dp_status.pipe_busy)
   `MSFA_ASSERT_NEXT(a_commit_frees, clock, reset, cmd.commit, req_ready)

endmodule

`default_nettype wire

// ----- rtl/msfa_dp.sv -----
// datapath: config registers, frame state, store scan pipeline, result register
`default_nettype none
`include "assert_macros.svh"

module msfa_dp #(
   parameter int CAPACITY   = msfa_pkg::DEF_CAPACITY,
   parameter int COORD_BITS = msfa_pkg::DEF_COORD_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire msfa_pkg::ctrl_cmd_type              cmd,
   output msfa_pkg::dp_status_type                  dp_status,
   input  wire logic [msfa_pkg::OP_W-1:0]           req_operation,
   input  wire logic [msfa_pkg::POS_W-1:0]          req_pos_x,
   input  wire logic [msfa_pkg::POS_W-1:0]          req_pos_y,
   input  wire logic [msfa_pkg::RESP_W-1:0]         req_response,
   input  wire logic [msfa_pkg::ID_W-1:0]           req_feature_id,
   input  wire logic                                csr_wr_en,
   input  wire logic [msfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [msfa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [msfa_pkg::STATUS_W-1:0]            rsp_status,
   output logic [msfa_pkg::ID_W-1:0]                rsp_new_id,
   output logic [msfa_pkg::COUNT_W-1:0]             rsp_stored_count
);

   import msfa_pkg::*;

   localparam int OW   = $clog2(CAPACITY + 1);
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CB   = COORD_BITS;
   localparam int SQW  = 2 * CB;
   localparam int DW   = SQW + 1;
   localparam int CMW  = (DW > SEP_W) ? DW : SEP_W;
   localparam int FCW  = (OW > MAXF_W) ? OW : MAXF_W;

   // configuration
   logic [RESP_W-1:0]  min_resp_ff;
   logic [SEP_W-1:0]   min_sep_ff;
   logic [MAXF_W-1:0]  max_feat_ff;
   logic [LIMIT_W-1:0] cand_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_resp_ff <= RST_MIN_RESP;
         min_sep_ff  <= RST_MIN_SEP;
         max_feat_ff <= RST_MAX_FEAT;
         cand_lim_ff <= RST_CAND_LIM;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_RESP: min_resp_ff <= csr_wdata[RESP_W-1:0];
            CSR_MIN_SEP:  min_sep_ff  <= csr_wdata[SEP_W-1:0];
            CSR_MAX_FEAT: max_feat_ff <= csr_wdata[MAXF_W-1:0];
            CSR_CAND_LIM: cand_lim_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // latched item
   logic [OP_W-1:0]   op_ff;
   logic [CB-1:0]     x_ff;
   logic [CB-1:0]     y_ff;
   logic [RESP_W-1:0] resp_ff;
   logic [ID_W-1:0]   fid_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         x_ff    <= CB'(req_pos_x);
         y_ff    <= CB'(req_pos_y);
         resp_ff <= req_response;
         fid_ff  <= req_feature_id;
      end
   end

   // frame state
   logic [OW-1:0]      occ_ff,     occ_in;
   logic [ID_W-1:0]    hid_ff,     hid_in;
   logic [LIMIT_W-1:0] seen_ff,    seen_in;
   logic               stopped_ff, stopped_in;

   logic occ_full;
   logic limit_hit;
   logic low_hit;

   assign occ_full  = occ_ff >= OW'(CAPACITY);
   assign limit_hit = (seen_ff >= cand_lim_ff) || (FCW'(occ_ff) >= FCW'(max_feat_ff)) ||
                      occ_full;
   assign low_hit   = stopped_ff || (resp_ff < min_resp_ff);

   // store scan pipeline
   logic [OW-1:0]  idx_ff;
   logic           v1_ff;
   logic           v2_ff;
   logic [SQW-1:0] sqx_ff;
   logic [SQW-1:0] sqy_ff;
   logic           close_ff;

   logic [2*CB-1:0] rd_data;
   logic [CB-1:0]   rd_x;
   logic [CB-1:0]   rd_y;
   logic [CB-1:0]   dx;
   logic [CB-1:0]   dy;
   logic [SQW-1:0]  dxe;
   logic [SQW-1:0]  dye;
   logic [DW-1:0]   dist_sum;

   assign rd_x     = rd_data[2*CB-1:CB];
   assign rd_y     = rd_data[CB-1:0];
   assign dx       = (x_ff > rd_x) ? (x_ff - rd_x) : (rd_x - x_ff);
   assign dy       = (y_ff > rd_y) ? (y_ff - rd_y) : (rd_y - y_ff);
   assign dxe      = SQW'(dx);
   assign dye      = SQW'(dy);
   assign dist_sum = DW'(sqx_ff) + DW'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.search_step;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_search) begin
         idx_ff   <= '0;
         close_ff <= 1'b0;
      end else begin
         if (cmd.search_step) begin
            idx_ff <= idx_ff + OW'(1);
         end
         if (v2_ff && (CMW'(dist_sum) <= CMW'(min_sep_ff))) begin
            close_ff <= 1'b1;
         end
      end
      if (v1_ff) begin
         sqx_ff <= dxe * dxe;
         sqy_ff <= dye * dye;
      end
   end

   // commit
   logic              wr_en;
   logic [STATUS_W-1:0] st_in;
   logic [ID_W-1:0]   id_in;

   always_comb begin
      occ_in     = occ_ff;
      hid_in     = hid_ff;
      seen_in    = seen_ff;
      stopped_in = stopped_ff;
      wr_en      = 1'b0;
      st_in      = ST_STORED;
      id_in      = '0;
      case (op_type'(op_ff))
         OP_CLEAR: begin
            occ_in     = '0;
            hid_in     = '0;
            seen_in    = '0;
            stopped_in = 1'b0;
         end
         OP_LOAD: begin
            seen_in    = '0;
            stopped_in = 1'b0;
            if (occ_full) begin
               st_in = ST_OVERFLOW;
            end else begin
               wr_en  = 1'b1;
               occ_in = occ_ff + OW'(1);
               if (fid_ff > hid_ff) begin
                  hid_in = fid_ff;
               end
            end
         end
         OP_CANDIDATE: begin
            if (limit_hit) begin
               st_in = ST_LIMIT;
            end else if (low_hit) begin
               stopped_in = 1'b1;
               st_in      = ST_LOWRESP;
            end else begin
               if (seen_ff != '1) begin
                  seen_in = seen_ff + LIMIT_W'(1);
               end
               if (close_ff) begin
                  st_in = ST_CLOSE;
               end else begin
                  wr_en  = 1'b1;
                  occ_in = occ_ff + OW'(1);
                  hid_in = hid_ff + ID_W'(1);
                  id_in  = hid_ff + ID_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         hid_ff     <= '0;
         seen_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (cmd.commit) begin
         occ_ff     <= occ_in;
         hid_ff     <= hid_in;
         seen_ff    <= seen_in;
         stopped_ff <= stopped_in;
      end
   end

   msfa_ram #(
      .WIDTH (2 * CB),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_en),
      .wr_addr (occ_ff[AW-1:0]),
      .wr_data ({x_ff, y_ff}),
      .rd_en   (cmd.search_step),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_new_id_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= st_in;
         rsp_new_id_ff <= id_in;
         rsp_count_ff  <= COUNT_W'(occ_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_id       = rsp_new_id_ff;
   assign rsp_stored_count = rsp_count_ff;

   assign dp_status.needs_search = (op_type'(op_ff) == OP_CANDIDATE) && !limit_hit && !low_hit;
   assign dp_status.issue_done   = idx_ff >= occ_ff;
   assign dp_status.pipe_busy    = v1_ff || v2_ff;
   assign dp_status.out_free     = !rsp_valid_ff || rsp_ready;

   `MSFA_ASSERT_IMPLY(a_occ_bounded, clock, reset, 1'b1, occ_ff <= OW'(CAPACITY))
   `MSFA_ASSERT_IMPLY(a_write_has_room, clock, reset, cmd.commit && wr_en, !occ_full)
   `MSFA_ASSERT_NEXT(a_count_matches, clock, reset, cmd.commit, rsp_stored_count == COUNT_W'(occ_ff))

endmodule

`default_nettype wire

// ----- rtl/min_separation_feature_admit_unit.sv -----
// top level of the minimum separation feature admit unit
`default_nettype none

// Admits new keypoints that keep a minimum squared distance from every
// tracked feature in a store of CAPACITY positions, one result item per
// input item. Items are handled one at a time. For a candidate that is
// checked against the store, the single read port of the store memory is
// scanned one entry per cycle through a two-stage square and compare
// pipeline that is drained before the result is formed. A finished result
// waits in an output register, so the next item is accepted while the
// previous result is still pending; a result that is still not taken when
// the next one is ready holds the block until it is.

module min_separation_feature_admit_unit #(
   parameter int CAPACITY   = msfa_pkg::DEF_CAPACITY,
   parameter int COORD_BITS = msfa_pkg::DEF_COORD_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [msfa_pkg::OP_W-1:0]       req_operation,
   input  wire logic [msfa_pkg::POS_W-1:0]      req_pos_x,
   input  wire logic [msfa_pkg::POS_W-1:0]      req_pos_y,
   input  wire logic [msfa_pkg::RESP_W-1:0]     req_response,
   input  wire logic [msfa_pkg::ID_W-1:0]       req_feature_id,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [msfa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [msfa_pkg::ID_W-1:0]            rsp_new_id,
   output logic [msfa_pkg::COUNT_W-1:0]         rsp_stored_count,
   input  wire logic                            csr_wr_en,
   input  wire logic [msfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [msfa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import msfa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   msfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   msfa_dp #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_response     (req_response),
      .req_feature_id   (req_feature_id),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_new_id       (rsp_new_id),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule

`default_nettype wire
